// File: hw/rtl/md2_pkg.sv
// MD2 digest block: shared constants, byte type and the pi substitution table.
// No dependencies; compiled first.
package md2_pkg;

    typedef logic [7:0] t_byte;

    localparam int BLOCK_BYTES = 16;
    localparam int MIX_BYTES   = 48;
    localparam int ROUNDS      = 18;
    localparam int BLK_AW      = $clog2(BLOCK_BYTES);
    localparam int MIX_AW      = $clog2(MIX_BYTES);

    // substitution derived from the digits of pi
    localparam t_byte PI_SBOX [0:255] = '{
        8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
        8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
        8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
        8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
        8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
        8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
        8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
        8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
        8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
        8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
        8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
        8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
        8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
        8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
        8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
        8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
        8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
        8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
        8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
        8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
        8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
        8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
        8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
        8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
        8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
        8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
        8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
        8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
        8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
        8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
        8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
        8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
    };

endpackage

// File: hw/rtl/md2_if.sv
// MD2 digest block: valid/ready channel interfaces for input items and digests.
// Depends on md2_pkg.
interface md2_in_if;
    import md2_pkg::*;
    logic  valid;
    logic  ready;
    logic  cmd;
    t_byte data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface md2_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_high;
    logic [63:0] digest_low;

    modport source (output valid, output digest_high, output digest_low, input ready);
    modport sink   (input valid, input digest_high, input digest_low, output ready);
endinterface

// File: hw/rtl/md2_ram.sv
// MD2 digest block: single-port-write RAM with a registered read port.
// Depends on md2_pkg for default sizes.
module md2_ram
    import md2_pkg::*;
#(
    parameter int DEPTH = MIX_BYTES,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/md2_message_digest.sv
// MD2 digest block top level: byte intake, checksum update, 18-round compression
// and digest readout. Depends on md2_pkg, md2_if (md2_in_if, md2_out_if) and md2_ram.
//
// Streams message bytes in and returns the 128-bit MD2 digest on a finish
// transaction (cmd = 1; data_byte is ignored). Each message byte passes through
// a read of the chaining and checksum entries, an XOR write and a block write.
// The checksum is updated byte by byte as data arrives. Every 16th byte triggers
// a compression of 18 rounds of 48 substitutions; its first read is issued during
// the last block write. The compression speed is set by the 48-byte mix RAM, which
// carries the chaining state in its first 16 entries and performs one dependent
// substitution per cycle through its single write port and registered read port.
// A finish pushes 1 to 16 pad bytes (the first through the read, XOR write and
// block write, each further one through an XOR write and a block write), then one
// compression, the checksum block, a second compression and the digest readout (a
// wait for a free output slot, then 16 shifts). The digest sits in an output
// register, so the next message may start while it waits to be taken; a second
// digest waits only if the first one is still pending. After the digest the
// chaining state, checksum and byte count return to zero (valid bits are
// cleared, so no clearing pass is needed after reset).
module md2_message_digest
    import md2_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    md2_in_if.sink      i_in,
    md2_out_if.source   o_out
);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;  // wait for a transaction
    localparam logic [2:0] S_XOR   = 3'd1;  // write chain^byte, update checksum (not for the checksum block)
    localparam logic [2:0] S_BUF   = 3'd2;  // write block byte, advance count
    localparam logic [2:0] S_COMP  = 3'd3;  // one substitution per cycle
    localparam logic [2:0] S_WAIT  = 3'd4;  // wait for free output slot
    localparam logic [2:0] S_RDOUT = 3'd5;  // shift chaining state into digest

    // what the byte being pushed belongs to
    localparam logic [1:0] PH_MSG = 2'd0;
    localparam logic [1:0] PH_PAD = 2'd1;
    localparam logic [1:0] PH_SUM = 2'd2;

    localparam logic [MIX_AW-1:0] J_LAST   = MIX_AW'(MIX_BYTES - 1);
    localparam logic [4:0]        RND_LAST = 5'(ROUNDS - 1);
    localparam logic [BLK_AW-1:0] F_LAST   = BLK_AW'(BLOCK_BYTES - 1);

    logic [2:0]             r_state, n_state;
    logic [1:0]             r_phase, n_phase;
    logic [BLK_AW-1:0]      r_fill,  n_fill;
    t_byte                  r_byte,  n_byte;
    t_byte                  r_sum_t, n_sum_t;   // last checksum byte written
    t_byte                  r_t,     n_t;       // mix chain value
    logic [MIX_AW-1:0]      r_j,     n_j;
    logic [4:0]             r_rnd,   n_rnd;
    logic [BLOCK_BYTES-1:0] r_chain_vld, n_chain_vld;
    logic [BLOCK_BYTES-1:0] r_sum_vld,   n_sum_vld;
    logic                   r_mix_rv, n_mix_rv;
    logic                   r_sum_rv, n_sum_rv;
    logic                   r_out_vld, n_out_vld;
    logic [127:0]           r_out,     n_out;

    // RAM ports
    logic              mix_we;
    logic [MIX_AW-1:0] mix_wa, mix_ra;
    t_byte             mix_wd, mix_q, mix_rd;
    logic              sum_we;
    logic [BLK_AW-1:0] sum_wa, sum_ra;
    t_byte             sum_wd, sum_q, sum_rd;

    logic              in_fire;
    logic [4:0]        pad_len;
    logic [BLK_AW-1:0] fill_inc;
    t_byte             push_byte;
    t_byte             mix_new;
    logic              j_last;

    md2_ram #(
        .DEPTH (MIX_BYTES),
        .WIDTH (8)
    ) u_mix_ram (
        .i_clk   (i_clk),
        .i_we    (mix_we),
        .i_waddr (mix_wa),
        .i_wdata (mix_wd),
        .i_raddr (mix_ra),
        .o_rdata (mix_q)
    );

    md2_ram #(
        .DEPTH (BLOCK_BYTES),
        .WIDTH (8)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_wa),
        .i_wdata (sum_wd),
        .i_raddr (sum_ra),
        .o_rdata (sum_q)
    );

    // chaining and checksum entries never written since the last digest read as zero
    assign mix_rd = r_mix_rv ? mix_q : 8'd0;
    assign sum_rd = r_sum_rv ? sum_q : 8'd0;

    assign in_fire  = i_in.valid && i_in.ready;
    assign pad_len  = 5'd16 - {1'b0, r_fill};
    assign fill_inc = r_fill + 1'b1;
    assign push_byte = (r_phase == PH_SUM) ? sum_rd : r_byte;
    assign mix_new  = mix_rd ^ PI_SBOX[r_t];
    assign j_last   = (r_j == J_LAST);

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_vld;
    assign o_out.digest_high = r_out[127:64];
    assign o_out.digest_low  = r_out[63:0];

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_fill      = r_fill;
        n_byte      = r_byte;
        n_sum_t     = r_sum_t;
        n_t         = r_t;
        n_j         = r_j;
        n_rnd       = r_rnd;
        n_chain_vld = r_chain_vld;
        n_sum_vld   = r_sum_vld;
        n_out_vld   = r_out_vld;
        n_out       = r_out;
        mix_we      = 1'b0;
        mix_wa      = '0;
        mix_wd      = '0;
        mix_ra      = '0;
        sum_we      = 1'b0;
        sum_wa      = r_fill;
        sum_wd      = '0;
        sum_ra      = r_fill;

        if (r_out_vld && o_out.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    mix_ra  = {2'b00, r_fill};
                    n_byte  = i_in.cmd ? {3'b000, pad_len} : i_in.data_byte;
                    n_phase = i_in.cmd ? PH_PAD : PH_MSG;
                    n_state = S_XOR;
                end
            end
            S_XOR: begin
                mix_we = 1'b1;
                mix_wa = {2'b10, r_fill};
                mix_wd = mix_rd ^ push_byte;
                // checksum block itself does not feed the checksum
                if (r_phase != PH_SUM) begin
                    sum_we              = 1'b1;
                    sum_wd              = sum_rd ^ PI_SBOX[push_byte ^ r_sum_t];
                    n_sum_t             = sum_wd;
                    n_sum_vld[r_fill]   = 1'b1;
                end
                n_byte  = push_byte;
                n_state = S_BUF;
            end
            S_BUF: begin
                mix_we = 1'b1;
                mix_wa = {2'b01, r_fill};
                mix_wd = r_byte;
                n_fill = fill_inc;
                if (r_fill == F_LAST) begin
                    mix_ra  = '0;
                    n_j     = '0;
                    n_rnd   = '0;
                    n_t     = '0;
                    n_state = S_COMP;
                end else if (r_phase == PH_MSG) begin
                    n_state = S_IDLE;
                end else begin
                    // next pad or checksum byte
                    mix_ra  = {2'b00, fill_inc};
                    sum_ra  = fill_inc;
                    n_state = S_XOR;
                end
            end
            S_COMP: begin
                mix_we = 1'b1;
                mix_wa = r_j;
                mix_wd = mix_new;
                if (r_j[MIX_AW-1:BLK_AW] == '0) begin
                    n_chain_vld[r_j[BLK_AW-1:0]] = 1'b1;
                end
                n_t    = j_last ? (mix_new + {3'b000, r_rnd}) : mix_new;
                n_j    = j_last ? '0 : (r_j + 1'b1);
                n_rnd  = j_last ? (r_rnd + 1'b1) : r_rnd;
                mix_ra = n_j;
                if (j_last && (r_rnd == RND_LAST)) begin
                    unique case (r_phase)
                        PH_MSG: n_state = S_IDLE;
                        PH_PAD: begin
                            n_phase = PH_SUM;
                            n_state = S_XOR;
                        end
                        default: n_state = S_WAIT;
                    endcase
                end
            end
            S_WAIT: begin
                if (!r_out_vld) begin
                    mix_ra  = '0;
                    n_j     = '0;
                    n_state = S_RDOUT;
                end
            end
            S_RDOUT: begin
                n_out  = {r_out[119:0], mix_rd};
                n_j    = r_j + 1'b1;
                mix_ra = n_j;
                if (r_j == MIX_AW'(BLOCK_BYTES - 1)) begin
                    // digest out, start a fresh message
                    n_out_vld   = 1'b1;
                    n_chain_vld = '0;
                    n_sum_vld   = '0;
                    n_sum_t     = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // read-data valid follows the address issued this cycle
    assign n_mix_rv = (mix_ra[MIX_AW-1:BLK_AW] != '0) || r_chain_vld[mix_ra[BLK_AW-1:0]];
    assign n_sum_rv = r_sum_vld[sum_ra];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_MSG;
            r_fill      <= '0;
            r_sum_t     <= '0;
            r_chain_vld <= '0;
            r_sum_vld   <= '0;
            r_out_vld   <= 1'b0;
            r_j         <= '0;
            r_rnd       <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_fill      <= n_fill;
            r_sum_t     <= n_sum_t;
            r_chain_vld <= n_chain_vld;
            r_sum_vld   <= n_sum_vld;
            r_out_vld   <= n_out_vld;
            r_j         <= n_j;
            r_rnd       <= n_rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte   <= n_byte;
        r_t      <= n_t;
        r_mix_rv <= n_mix_rv;
        r_sum_rv <= n_sum_rv;
        r_out    <= n_out;
    end

`ifndef ASSERT_OFF
    // compression only starts once the block count has wrapped
    a_comp_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP) |-> (r_fill == '0))
        else $error("compression running with a partial block");

    // a digest appears only at the end of the readout sweep
    a_out_from_rdout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == S_RDOUT))
        else $error("digest raised outside readout");

    // readout never overwrites a pending digest
    a_rdout_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDOUT) |-> !r_out_vld)
        else $error("readout while output slot full");

    // emitting a digest resets chaining state and checksum
    a_clear_on_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ((r_chain_vld == '0) && (r_sum_vld == '0) && (r_fill == '0)))
        else $error("state not cleared after digest");
`endif

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for md2_message_digest: directed digests, output hold-off and
// random messages under several idle patterns. Depends on md2_pkg, md2_if and the RTL.
module tb;
    import md2_pkg::*;

    localparam logic CMD_BYTE   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam int     ITEMS_PER_PHASE = 430;
    localparam int     HOLD_OFF_CYCLES = 8000;
    localparam int     TAIL_CYCLES     = 200;
    localparam int     MAX_REPORTS     = 10;
    // worst case: every transaction a finish plus stalls, taken well over twice
    localparam longint MAX_CYCLES      = 12_000_000;

    // idle percentages per phase: none, sender, receiver, both
    localparam logic [3:0][7:0] SEND_IDLE_PCT  = {8'd35, 8'd0, 8'd69, 8'd0};
    localparam logic [3:0][7:0] RECV_STALL_PCT = {8'd35, 8'd69, 8'd0, 8'd0};

    typedef struct packed {
        logic [63:0] high;
        logic [63:0] low;
    } digest_t;

    typedef struct {
        logic    cmd;
        t_byte   data;
        bit      typed;
        digest_t digest;
    } stim_row_t;

    localparam digest_t EMPTY_DIGEST = 128'h8350e5a3e24c153df2275c9f80692773;
    localparam digest_t ABC_DIGEST   = 128'hda853b0d3f88d99b30283a69e6ded6bb;

    // directed rows; digests typed in only for the textbook vectors
    stim_row_t dir_rows [23] = '{
        '{CMD_FINISH, 8'hFF, 1'b1, EMPTY_DIGEST},   // empty message straight after reset
        '{CMD_BYTE,   8'h61, 1'b0, '0},
        '{CMD_BYTE,   8'h62, 1'b0, '0},
        '{CMD_BYTE,   8'h63, 1'b0, '0},
        '{CMD_FINISH, 8'h00, 1'b1, ABC_DIGEST},
        '{CMD_FINISH, 8'h5A, 1'b1, EMPTY_DIGEST},   // state cleared, data byte ignored
        '{CMD_BYTE,   8'h00, 1'b0, '0},             // one full block of edge values
        '{CMD_BYTE,   8'hFF, 1'b0, '0},
        '{CMD_BYTE,   8'h55, 1'b0, '0},
        '{CMD_BYTE,   8'hAA, 1'b0, '0},
        '{CMD_BYTE,   8'h01, 1'b0, '0},
        '{CMD_BYTE,   8'h02, 1'b0, '0},
        '{CMD_BYTE,   8'h04, 1'b0, '0},
        '{CMD_BYTE,   8'h08, 1'b0, '0},
        '{CMD_BYTE,   8'h10, 1'b0, '0},
        '{CMD_BYTE,   8'h20, 1'b0, '0},
        '{CMD_BYTE,   8'h40, 1'b0, '0},
        '{CMD_BYTE,   8'h80, 1'b0, '0},
        '{CMD_BYTE,   8'hFE, 1'b0, '0},
        '{CMD_BYTE,   8'h7F, 1'b0, '0},
        '{CMD_BYTE,   8'h0F, 1'b0, '0},
        '{CMD_BYTE,   8'hF0, 1'b0, '0},
        '{CMD_FINISH, 8'hC3, 1'b0, '0}              // last block full: pad is a whole block
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    md2_in_if  in_if ();
    md2_out_if out_if ();

    md2_message_digest u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------------------
    // Digest predictor: own copy of chaining state, checksum, block buffer and fill count
    // ---------------------------------------------------------------------------------
    t_byte             pred_chain [BLOCK_BYTES] = '{default: '0};
    t_byte             pred_sum   [BLOCK_BYTES] = '{default: '0};
    t_byte             pred_block [BLOCK_BYTES] = '{default: '0};
    logic [BLK_AW-1:0] pred_fill = '0;

    digest_t digest_q [$];      // digests owed by the block, oldest first
    digest_t want_digest;

    int     items_sent    = 0;
    int     messages_sent = 0;
    int     digests_seen  = 0;
    int     fail_count    = 0;
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     hold_off_req   = 0;
    bit     hold_taken     = 1'b0;
    int     hold_left      = 0;
    longint cycle_count    = 0;

    // 18 rounds over the 48-byte mix, then the checksum update with the same block
    function automatic void md2_compress();
        t_byte mix [MIX_BYTES];
        t_byte t;
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            mix[i]                   = pred_chain[i];
            mix[i + BLOCK_BYTES]     = pred_block[i];
            mix[i + 2 * BLOCK_BYTES] = pred_chain[i] ^ pred_block[i];
        end
        t = '0;
        for (int r = 0; r < ROUNDS; r++) begin
            for (int j = 0; j < MIX_BYTES; j++) begin
                mix[j] = mix[j] ^ PI_SBOX[t];
                t      = mix[j];
            end
            t = t_byte'(t + r);
        end
        for (int i = 0; i < BLOCK_BYTES; i++)
            pred_chain[i] = mix[i];
        t = pred_sum[BLOCK_BYTES - 1];
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            pred_sum[i] = pred_sum[i] ^ PI_SBOX[pred_block[i] ^ t];
            t           = pred_sum[i];
        end
    endfunction

    function automatic void md2_absorb(input t_byte b);
        pred_block[pred_fill] = b;
        pred_fill = pred_fill + 1'b1;
        if (pred_fill == '0)
            md2_compress();
    endfunction

    // pad 1..16 bytes of the pad length, fold in the checksum, read out and clear
    function automatic digest_t md2_finish();
        digest_t d;
        t_byte   pad;
        t_byte   sum_copy [BLOCK_BYTES];
        d   = '0;
        pad = t_byte'(BLOCK_BYTES - pred_fill);
        repeat (pad) md2_absorb(pad);
        sum_copy = pred_sum;
        for (int i = 0; i < BLOCK_BYTES; i++)
            md2_absorb(sum_copy[i]);
        for (int i = 0; i < 8; i++) begin
            d.high = {d.high[55:0], pred_chain[i]};
            d.low  = {d.low[55:0],  pred_chain[i + 8]};
        end
        pred_chain = '{default: '0};
        pred_sum   = '{default: '0};
        pred_fill  = '0;
        return d;
    endfunction

    // ---------------------------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------------------------
    // Offers one transaction after a random gap; predicts once it is accepted.
    task automatic send_item(input logic cmd, input t_byte data, input bit typed,
                             input digest_t typed_digest);
        digest_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid     <= 1'b0;
            in_if.data_byte <= t_byte'($urandom);
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.cmd       <= cmd;
        in_if.data_byte <= data;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        items_sent++;
        if (cmd == CMD_FINISH) begin
            predicted = md2_finish();
            digest_q.push_back(typed ? typed_digest : predicted);
            messages_sent++;
        end else begin
            md2_absorb(data);
        end
    endtask

    // Random content, skewed towards all-zero and all-one bytes now and then.
    task automatic send_message(input int msg_len);
        t_byte b;
        for (int i = 0; i < msg_len; i++) begin
            if ($urandom_range(7) == 0)
                b = $urandom_range(1) ? 8'hFF : 8'h00;
            else
                b = t_byte'($urandom);
            send_item(CMD_BYTE, b, 1'b0, '0);
        end
        send_item(CMD_FINISH, t_byte'($urandom), 1'b0, '0);
    endtask

    // Sender goes quiet until every owed digest has been taken.
    task automatic wait_for_digests();
        in_if.valid <= 1'b0;
        while (digest_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] expd,
                                   input logic [63:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("ERROR: %s mismatch at %0t: expected %h, got %h", field, $realtime, expd,
                     got);
    endtask

    // ---------------------------------------------------------------------------------
    // Receiver side: random stalls, a long hold-off on request, and the digest check
    // ---------------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                digests_seen++;
                if (digest_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("ERROR: unexpected digest %h %h at %0t", out_if.digest_high,
                                 out_if.digest_low, $realtime);
                end else begin
                    want_digest = digest_q.pop_front();
                    if (out_if.digest_high !== want_digest.high)
                        report_mismatch("digest_high", want_digest.high, out_if.digest_high);
                    if (out_if.digest_low !== want_digest.low)
                        report_mismatch("digest_low", want_digest.low, out_if.digest_low);
                end
            end
            if (hold_off_req != 0 && !hold_taken) begin
                hold_left  = hold_off_req;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES) begin
            $display("ERROR: timeout after %0d cycles, %0d digests outstanding", cycle_count,
                     digest_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------------------
    initial begin
        int phase_end;
        int msg_len;

        in_if.valid     = 1'b0;
        in_if.cmd       = CMD_BYTE;
        in_if.data_byte = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed vectors, no idling
        foreach (dir_rows[r])
            send_item(dir_rows[r].cmd, dir_rows[r].data, dir_rows[r].typed,
                      dir_rows[r].digest);
        wait_for_digests();

        // Receiver holds off while short messages keep coming: the digest register fills,
        // a second digest queues behind it and the input must stall.
        hold_off_req = HOLD_OFF_CYCLES;
        repeat (5) send_message($urandom_range(3));
        wait_for_digests();

        // Random messages, one phase per idle pattern
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = SEND_IDLE_PCT[p];
            recv_stall_pct = RECV_STALL_PCT[p];
            phase_end      = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end) begin
                case ($urandom_range(9))
                    0:       msg_len = 0;
                    1:       msg_len = 16 * $urandom_range(1, 3);
                    2:       msg_len = 16 * $urandom_range(0, 2) + 15;
                    3:       msg_len = $urandom_range(33, 70);
                    default: msg_len = $urandom_range(1, 24);
                endcase
                send_message(msg_len);
            end
            wait_for_digests();
        end

        // Nothing owed; give a stray digest time to show up
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Summary: %0d transactions in %0d messages, %0d digests taken, %0d errors",
                 items_sent, messages_sent, digests_seen, fail_count);
        $display("Summary: phases with no idling, sender gaps, receiver stalls and both, plus "
                 , "a %0d-cycle output hold-off", HOLD_OFF_CYCLES);
        if (fail_count == 0 && digest_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/md2_pkg.sv
hw/rtl/md2_if.sv
hw/rtl/md2_ram.sv
hw/rtl/md2_message_digest.sv
tb/sv/tb.sv
